/* design/ofir_pkg.sv */
// Shared types, constants and twiddle lookup for the overlap-add FFT filter.
package ofir_pkg;

  localparam int FFT_POINTS_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_BITS        = 6;
  localparam int TW_BITS         = 18;
  localparam int SPEC_BITS       = 36;
  localparam int ACC_BITS        = 64;
  localparam int OV_BITS         = 32;
  localparam int COEF_BITS       = 16;

  localparam logic [1:0] REQ_COEF   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [5:0]          coef_index;
    logic signed [15:0]  coef_real;
    logic signed [15:0]  coef_imag;
    logic signed [15:0]  sample_in;
    logic                flush;
  } in_t;

  typedef struct packed {
    logic signed [15:0]  sample_out;
    logic                last;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FWD_RD, ST_FWD_MC, ST_FWD_MS, ST_FWD_AS, ST_FWD_END,
    ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_MUL6,
    ST_INV_RD, ST_INV_MC, ST_INV_MS, ST_INV_AS, ST_INV_WR,
    ST_OUT_RD, ST_OUT_ADD, ST_OUT_SAT, ST_OUT_WAIT,
    ST_OV_RD, ST_OV_ADD, ST_OV_DONE
  } state_t;

  localparam logic signed [TW_BITS-1:0] QUARTER_COS [17] = '{
    18'sd32768, 18'sd32610, 18'sd32138, 18'sd31357, 18'sd30274, 18'sd28899,
    18'sd27246, 18'sd25330, 18'sd23170, 18'sd20788, 18'sd18205, 18'sd15447,
    18'sd12540, 18'sd9512,  18'sd6393,  18'sd3212,  18'sd0
  };

  // cos(2*pi*m/64) in Q15, from a quarter-wave table
  function automatic logic signed [TW_BITS-1:0] tw_cos(input logic [5:0] m);
    logic [6:0] mm;
    logic [6:0] idx;
    logic       neg;
    mm = {1'b0, m};
    if (mm <= 7'd16) begin
      idx = mm;
      neg = 1'b0;
    end else if (mm <= 7'd32) begin
      idx = 7'd32 - mm;
      neg = 1'b1;
    end else if (mm <= 7'd48) begin
      idx = mm - 7'd32;
      neg = 1'b1;
    end else begin
      idx = 7'd64 - mm;
      neg = 1'b0;
    end
    return neg ? -QUARTER_COS[idx[4:0]] : QUARTER_COS[idx[4:0]];
  endfunction

endpackage

/* design/ofir_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
module ofir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/fft_overlap_add_fir_filter_top.sv */
// Top level of the overlap-add FFT block FIR filter.
//
//  channel | signals                          | carries
//  --------+----------------------------------+----------------------------------------
//  in      | in_valid, in_ready, in_data      | one request: coef write, sample, clear
//  out     | out_valid, out_ready, out_data   | one filtered sample per buffered sample
//  cfg     | cfg_valid, cfg_ready, cfg_data   | filter length P (always ready)
//
// Coefficient, clear and non-frame-ending sample requests are handled without leaving idle.
// A frame of C samples runs the forward DFT with bin multiply, then the inverse, then the
// outputs, which stall on out_ready, then the overlap update; the DFTs and the bin multiply
// share one multiplier with a MAC accumulator.
// in_ready is low while a frame is processed. Reset is synchronous; no clearing pass is
// needed, overlap entries carry valid bits that reset and clear requests drop at once.
module fft_overlap_add_fir_filter_top
  import ofir_pkg::*;
#(
  parameter int FFT_POINTS  = FFT_POINTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam int AW       = $clog2(FFT_POINTS);
  localparam int CW       = AW + 1;
  localparam int HALF     = FFT_POINTS / 2 + 1;
  localparam int BW       = $clog2(HALF);
  localparam int TW_SHIFT = 6 - AW;
  localparam int PW       = SPEC_BITS + TW_BITS;

  localparam logic [CW-1:0] N_C    = CW'(FFT_POINTS);
  localparam logic [BW-1:0] K_LAST = BW'(HALF - 1);
  localparam logic [AW-1:0] N_LAST = AW'(FFT_POINTS - 1);
  localparam logic signed [ACC_BITS-1:0] RND15 = 64'sd16384;
  localparam logic signed [ACC_BITS-1:0] RND14 = 64'sd8192;
  localparam logic signed [ACC_BITS-1:0] RNDSH = 64'sd1 <<< (AW - 1);
  localparam logic signed [ACC_BITS-1:0] SMAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_BITS-1:0] SMIN  = -(64'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] OMAX  = 64'sd2147483647;
  localparam logic signed [ACC_BITS-1:0] OMIN  = -64'sd2147483648;

  // sequencer and loop state
  state_t                       state, state_next;
  logic [CFG_BITS-1:0]          filt_len;
  logic [CW-1:0]                fill;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                n_idx;
  logic [BW-1:0]                k_idx;
  logic [5:0]                   ph;
  logic [5:0]                   step;
  logic [FFT_POINTS-1:0]        ov_valid;
  logic                         ov_use;

  // datapath registers
  logic signed [ACC_BITS-1:0]   acc_re, acc_im, sum;
  logic signed [SPEC_BITS-1:0]  xr, xi;
  logic signed [PW-1:0]         prod;

  // derived values
  logic [6:0]                   fl7;
  logic [CW-1:0]                eff_p, frame_len, tail, fill_inc;
  logic                         in_fire, smp_fire, start;
  logic [CW:0]                  src;
  logic                         src_in;
  logic signed [ACC_BITS-1:0]   prod_ext, prod_w, r15_re, r15_im, r14_re, r14_im;
  logic signed [ACC_BITS-1:0]   ov_ext, ov_sum, ov_sat, shv, out_sat;
  logic                         wgt2;
  logic signed [SPEC_BITS-1:0]  mul_a;
  logic signed [TW_BITS-1:0]    mul_b, cos_v, sin_v;
  logic [6:0]                   k_plus, n_plus;

  // memory ports
  logic                         fr_we, fr_re, cf_we, cf_re, sr_we, si_we, sp_re;
  logic                         tr_we, tr_re, ov_we, ov_re;
  logic [AW-1:0]                tr_raddr, ov_raddr;
  logic [SAMPLE_BITS-1:0]       fr_rdata;
  logic [COEF_BITS-1:0]         cr_rdata, ci_rdata;
  logic [SPEC_BITS-1:0]         sr_rdata, si_rdata;
  logic [ACC_BITS-1:0]          tr_rdata;
  logic [OV_BITS-1:0]           ov_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign smp_fire  = in_fire && (in_data.req_type == REQ_SAMPLE);

  // effective filter length: below 1 acts as 1, above N acts as N
  assign fl7 = 7'(filt_len);
  always_comb begin
    if (fl7 == 7'd0) begin
      eff_p = CW'(1);
    end else if (fl7 > 7'(FFT_POINTS)) begin
      eff_p = N_C;
    end else begin
      eff_p = CW'(fl7);
    end
  end
  assign frame_len = N_C - eff_p + CW'(1);
  assign tail      = eff_p - CW'(1);
  assign fill_inc  = (fill == N_C) ? fill : fill + CW'(1);
  assign start     = (fill_inc >= frame_len) || in_data.flush;

  // overlap source index for the tail update
  assign src    = {1'b0, cnt} + {1'b0, n_idx};
  assign src_in = (src < {1'b0, N_C});

  assign k_plus = 7'(k_idx) + 7'd1;
  assign n_plus = 7'(n_idx) + 7'd1;

  // shared multiplier and rounding
  assign cos_v    = tw_cos(ph);
  assign sin_v    = tw_cos(ph + 6'd48);
  assign prod_ext = ACC_BITS'(prod);
  assign wgt2     = (k_idx != '0) && (k_idx != K_LAST);
  assign prod_w   = wgt2 ? (prod_ext <<< 1) : prod_ext;
  assign r15_re   = (acc_re + RND15) >>> 15;
  assign r15_im   = (acc_im + RND15) >>> 15;
  assign r14_re   = (acc_re + RND14) >>> 14;
  assign r14_im   = (acc_im + RND14) >>> 14;

  assign ov_ext = ov_use ? ACC_BITS'($signed(ov_rdata)) : '0;
  assign ov_sum = $signed(tr_rdata) + ov_ext;
  assign ov_sat = (ov_sum > OMAX) ? OMAX : ((ov_sum < OMIN) ? OMIN : ov_sum);
  assign shv     = sum >>> AW;
  assign out_sat = (shv > SMAX) ? SMAX : ((shv < SMIN) ? SMIN : shv);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (smp_fire && start) state_next = ST_FWD_RD;
      ST_FWD_RD:  state_next = ST_FWD_MC;
      ST_FWD_MC:  state_next = ST_FWD_MS;
      ST_FWD_MS:  state_next = ST_FWD_AS;
      ST_FWD_AS:  state_next = (n_idx + CW'(1) == cnt) ? ST_FWD_END : ST_FWD_RD;
      ST_FWD_END: state_next = ST_MUL1;
      ST_MUL1:    state_next = ST_MUL2;
      ST_MUL2:    state_next = ST_MUL3;
      ST_MUL3:    state_next = ST_MUL4;
      ST_MUL4:    state_next = ST_MUL5;
      ST_MUL5:    state_next = ST_MUL6;
      ST_MUL6:    state_next = (k_idx == K_LAST) ? ST_INV_RD : ST_FWD_RD;
      ST_INV_RD:  state_next = ST_INV_MC;
      ST_INV_MC:  state_next = ST_INV_MS;
      ST_INV_MS:  state_next = ST_INV_AS;
      ST_INV_AS:  state_next = (k_idx == K_LAST) ? ST_INV_WR : ST_INV_RD;
      ST_INV_WR:  state_next = (n_idx[AW-1:0] == N_LAST) ? ST_OUT_RD : ST_INV_RD;
      ST_OUT_RD:  state_next = ST_OUT_ADD;
      ST_OUT_ADD: state_next = ST_OUT_SAT;
      ST_OUT_SAT: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_ready) begin
          if (n_idx + CW'(1) != cnt) begin
            state_next = ST_OUT_RD;
          end else if (tail == '0) begin
            state_next = ST_OV_DONE;
          end else begin
            state_next = ST_OV_RD;
          end
        end
      end
      ST_OV_RD:   state_next = ST_OV_ADD;
      ST_OV_ADD:  state_next = (n_idx + CW'(1) == tail) ? ST_OV_DONE : ST_OV_RD;
      ST_OV_DONE: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory strobes and multiplier operands
  always_comb begin
    fr_we = smp_fire && (fill != N_C);
    cf_we = in_fire && (in_data.req_type == REQ_COEF) && (7'(in_data.coef_index) < 7'(HALF));
    fr_re = (state == ST_FWD_RD);
    cf_re = (state == ST_FWD_END);
    sr_we = (state == ST_MUL4);
    si_we = (state == ST_MUL6);
    sp_re = (state == ST_INV_RD);
    tr_we = (state == ST_INV_WR);
    ov_we = (state == ST_OV_ADD);
    tr_re = (state == ST_OUT_RD) || (state == ST_OV_RD);
    ov_re = tr_re;
    tr_raddr = (state == ST_OV_RD) ? src[AW-1:0] : n_idx[AW-1:0];
    ov_raddr = tr_raddr;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_FWD_MC: begin
        mul_a = SPEC_BITS'($signed(fr_rdata));
        mul_b = cos_v;
      end
      ST_FWD_MS: begin
        mul_a = SPEC_BITS'($signed(fr_rdata));
        mul_b = sin_v;
      end
      ST_MUL1: begin
        mul_a = xr;
        mul_b = TW_BITS'($signed(cr_rdata));
      end
      ST_MUL2: begin
        mul_a = xi;
        mul_b = TW_BITS'($signed(ci_rdata));
      end
      ST_MUL3: begin
        mul_a = xr;
        mul_b = TW_BITS'($signed(ci_rdata));
      end
      ST_MUL4: begin
        mul_a = xi;
        mul_b = TW_BITS'($signed(cr_rdata));
      end
      ST_INV_MC: begin
        mul_a = $signed(sr_rdata);
        mul_b = cos_v;
      end
      ST_INV_MS: begin
        mul_a = $signed(si_rdata);
        mul_b = sin_v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      filt_len  <= CFG_BITS'(1);
      fill      <= '0;
      ov_valid  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        filt_len <= cfg_data;
      end
      if (smp_fire) begin
        fill <= start ? '0 : fill_inc;
      end
      if (in_fire && (in_data.req_type == REQ_CLEAR)) begin
        ov_valid <= '0;
      end
      if (state == ST_OV_ADD) begin
        ov_valid[n_idx[AW-1:0]] <= 1'b1;
      end
      if (state == ST_OV_DONE) begin
        for (int i = 0; i < FFT_POINTS; i++) begin
          if (CW'(i) >= tail) begin
            ov_valid[i] <= 1'b0;
          end
        end
      end
      if (state == ST_OUT_SAT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath and loop counters
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        cnt    <= fill_inc;
        n_idx  <= '0;
        k_idx  <= '0;
        ph     <= '0;
        step   <= '0;
        acc_re <= '0;
        acc_im <= '0;
      end
      ST_FWD_MS: acc_re <= acc_re + prod_ext;
      ST_FWD_AS: begin
        acc_im <= acc_im - prod_ext;
        n_idx  <= n_idx + CW'(1);
        ph     <= ph + step;
      end
      ST_FWD_END: begin
        xr <= SPEC_BITS'(r15_re);
        xi <= SPEC_BITS'(r15_im);
      end
      ST_MUL2: acc_re <= prod_ext;
      ST_MUL3: acc_re <= acc_re - prod_ext;
      ST_MUL4: acc_im <= prod_ext;
      ST_MUL5: acc_im <= acc_im + prod_ext;
      ST_MUL6: begin
        n_idx  <= '0;
        ph     <= '0;
        acc_re <= '0;
        acc_im <= '0;
        if (k_idx == K_LAST) begin
          k_idx <= '0;
          step  <= '0;
        end else begin
          k_idx <= BW'(k_plus);
          step  <= 6'(k_plus << TW_SHIFT);
        end
      end
      ST_INV_MS: acc_re <= acc_re + prod_w;
      ST_INV_AS: begin
        acc_re <= acc_re - prod_w;
        k_idx  <= BW'(k_plus);
        ph     <= ph + step;
      end
      ST_INV_WR: begin
        k_idx  <= '0;
        ph     <= '0;
        acc_re <= '0;
        step   <= 6'(n_plus << TW_SHIFT);
        n_idx  <= (n_idx[AW-1:0] == N_LAST) ? '0 : CW'(n_plus);
      end
      ST_OUT_RD:  ov_use <= ov_valid[n_idx[AW-1:0]];
      ST_OUT_ADD: sum <= ov_sum + RNDSH;
      ST_OUT_SAT: begin
        out_data.sample_out <= out_sat[15:0];
        out_data.last       <= (n_idx + CW'(1) == cnt);
      end
      ST_OUT_WAIT: begin
        if (out_ready) begin
          n_idx <= (n_idx + CW'(1) == cnt) ? '0 : n_idx + CW'(1);
        end
      end
      ST_OV_RD:  ov_use <= src_in && ov_valid[src[AW-1:0]];
      ST_OV_ADD: n_idx <= n_idx + CW'(1);
      default: begin
      end
    endcase
  end

  ofir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FFT_POINTS)) u_frame (
    .clk(clk), .we(fr_we), .waddr(fill[AW-1:0]),
    .wdata(SAMPLE_BITS'($unsigned(in_data.sample_in))),
    .re(fr_re), .raddr(n_idx[AW-1:0]), .rdata(fr_rdata)
  );

  ofir_ram #(.WIDTH(COEF_BITS), .DEPTH(HALF)) u_coef_re (
    .clk(clk), .we(cf_we), .waddr(in_data.coef_index[BW-1:0]), .wdata(in_data.coef_real),
    .re(cf_re), .raddr(k_idx), .rdata(cr_rdata)
  );

  ofir_ram #(.WIDTH(COEF_BITS), .DEPTH(HALF)) u_coef_im (
    .clk(clk), .we(cf_we), .waddr(in_data.coef_index[BW-1:0]), .wdata(in_data.coef_imag),
    .re(cf_re), .raddr(k_idx), .rdata(ci_rdata)
  );

  ofir_ram #(.WIDTH(SPEC_BITS), .DEPTH(HALF)) u_spec_re (
    .clk(clk), .we(sr_we), .waddr(k_idx), .wdata(SPEC_BITS'(r14_re)),
    .re(sp_re), .raddr(k_idx), .rdata(sr_rdata)
  );

  ofir_ram #(.WIDTH(SPEC_BITS), .DEPTH(HALF)) u_spec_im (
    .clk(clk), .we(si_we), .waddr(k_idx), .wdata(SPEC_BITS'(r14_im)),
    .re(sp_re), .raddr(k_idx), .rdata(si_rdata)
  );

  ofir_ram #(.WIDTH(ACC_BITS), .DEPTH(FFT_POINTS)) u_work (
    .clk(clk), .we(tr_we), .waddr(n_idx[AW-1:0]), .wdata(r15_re),
    .re(tr_re), .raddr(tr_raddr), .rdata(tr_rdata)
  );

  ofir_ram #(.WIDTH(OV_BITS), .DEPTH(FFT_POINTS)) u_overlap (
    .clk(clk), .we(ov_we), .waddr(n_idx[AW-1:0]), .wdata(ov_sat[OV_BITS-1:0]),
    .re(ov_re), .raddr(ov_raddr), .rdata(ov_rdata)
  );

endmodule

/* test/fft_overlap_add_fir_filter_top_tb.sv */
// Self-checking testbench for the overlap-add FFT block FIR filter top level.
module fft_overlap_add_fir_filter_top_tb
  import ofir_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int NBINS = NPTS / 2 + 1;
  localparam int LOG2N = 6;
  // Room for the overlap update that follows the last output of a frame.
  localparam int SETTLE = 100;

  // Quarter-wave cosine in Q15; the other quadrants are folded from it.
  localparam longint COS_TAB [17] = '{
    32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
    20788, 18205, 15447, 12540, 9512, 6393, 3212, 0
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_BITS-1:0] cfg_data;

  fft_overlap_add_fir_filter_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Filter state as the testbench tracks it.
  int unsigned filt_len;
  int frame_buf [NPTS];
  int unsigned frame_cnt;
  int coef_re [NBINS];
  int coef_im [NBINS];
  int ovl [NPTS];
  longint work [NPTS];

  out_t pending_filtered [$];   // filtered samples still owed by the block
  int errors;
  bit streaming_out;            // output stalls are only applied while this is clear

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #500ms;
    $display("fft_overlap_add_fir_filter_top: mismatch");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint cos_q15(input int unsigned m);
    m = m & 63;
    if (m <= 16) return COS_TAB[m];
    if (m <= 32) return -COS_TAB[32 - m];
    if (m <= 48) return -COS_TAB[m - 32];
    return COS_TAB[64 - m];
  endfunction

  function automatic longint sin_q15(input int unsigned m);
    return cos_q15(m + 48);
  endfunction

  // Add half an LSB, then floor (arithmetic shift).
  function automatic longint rnd_shift(input longint v, input int s);
    longint t;
    t = v + (longint'(1) << (s - 1));
    return t >>> s;
  endfunction

  function automatic int unsigned eff_len();
    if (filt_len < 1) return 1;
    if (filt_len > NPTS) return NPTS;
    return filt_len;
  endfunction

  function automatic int sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // Convolve the buffered frame, queue one filtered sample per entry, fold tail into overlap.
  function automatic void filter_frame(input int unsigned cnt);
    longint sre [NBINS];
    longint sim [NBINS];
    longint ar, ai, xr, xi, acc, v;
    int nov [NPTS];
    int unsigned tail, src;
    out_t o;
    tail = eff_len() - 1;
    for (int k = 0; k < NBINS; k++) begin
      ar = 0;
      ai = 0;
      for (int n = 0; n < cnt && n < NPTS; n++) begin
        ar += longint'(frame_buf[n]) * cos_q15((n * k) & 63);
        ai -= longint'(frame_buf[n]) * sin_q15((n * k) & 63);
      end
      xr = rnd_shift(ar, 15);
      xi = rnd_shift(ai, 15);
      sre[k] = rnd_shift(xr * coef_re[k] - xi * coef_im[k], 14);
      sim[k] = rnd_shift(xr * coef_im[k] + xi * coef_re[k], 14);
    end
    for (int n = 0; n < NPTS; n++) begin
      acc = sre[0] * 32768;
      acc += (n[0] ? -sre[NPTS / 2] : sre[NPTS / 2]) * 32768;
      for (int k = 1; k < NPTS / 2; k++)
        acc += 2 * (sre[k] * cos_q15((n * k) & 63) - sim[k] * sin_q15((n * k) & 63));
      work[n] = rnd_shift(acc, 15);
    end
    for (int n = 0; n < cnt; n++) begin
      v = rnd_shift(work[n] + longint'(ovl[n]), LOG2N);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      o.sample_out = v[15:0];
      o.last = (n + 1 == cnt);
      pending_filtered.push_back(o);
    end
    for (int k = 0; k < NPTS; k++) begin
      v = 0;
      if (k < tail) begin
        src = cnt + k;
        if (src < NPTS) v = ovl[src];
        v += work[src & (NPTS - 1)];
      end
      nov[k] = sat32(v);
    end
    ovl = nov;
    frame_cnt = 0;
  endfunction

  function automatic void apply_request(input in_t r);
    case (r.req_type)
      REQ_COEF: begin
        if (r.coef_index < NBINS) begin
          coef_re[r.coef_index] = int'(r.coef_real);
          coef_im[r.coef_index] = int'(r.coef_imag);
        end
      end
      REQ_CLEAR: begin
        foreach (ovl[i]) ovl[i] = 0;
      end
      REQ_SAMPLE: begin
        if (frame_cnt < NPTS) frame_buf[frame_cnt] = int'(r.sample_in);
        frame_cnt++;
        if (frame_cnt > NPTS) frame_cnt = NPTS;
        if (frame_cnt >= NPTS - eff_len() + 1 || r.flush) filter_frame(frame_cnt);
      end
      default: ;   // unknown request type is ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Mostly back-to-back or short gaps, occasionally a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one request; valid stays high into the next call when no gap follows.
  task automatic send_request(input in_t r, input int gap);
    @(negedge clk);
    in_data = r;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_request(r);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Let every owed sample come back, then cover the trailing overlap update.
  task automatic drain();
    idle_input();
    while (pending_filtered.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_length(input int unsigned p);
    drain();
    cfg_data = p[CFG_BITS-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    filt_len = p & 63;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_t coef_req(input int idx, input int re, input int im);
    in_t r;
    r = '0;
    r.req_type = REQ_COEF;
    r.coef_index = idx[5:0];
    r.coef_real = re[15:0];
    r.coef_imag = im[15:0];
    return r;
  endfunction

  function automatic in_t sample_req(input int s, input bit fl);
    in_t r;
    r = '0;
    r.req_type = REQ_SAMPLE;
    r.sample_in = s[15:0];
    r.flush = fl;
    // unused fields carry noise; the block must ignore them
    r.coef_index = 6'($urandom);
    r.coef_real = 16'($urandom);
    r.coef_imag = 16'($urandom);
    return r;
  endfunction

  function automatic in_t misc_req(input logic [1:0] kind);
    in_t r;
    r = in_t'($bits(in_t)'({$urandom, $urandom}));
    r.req_type = kind;
    return r;
  endfunction

  function automatic int rand_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32767;
    if (r < 20) return -32768;
    if (r < 55) return $signed($urandom_range(0, 4095)) - 2048;
    return $signed(16'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Output checker: compare each accepted sample with the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_filtered.size() == 0) begin
        report("unexpected output sample", int'(out_data.sample_out), 0);
      end else begin
        want = pending_filtered.pop_front();
        if (out_data.sample_out !== want.sample_out)
          report("sample_out", int'(out_data.sample_out), int'(want.sample_out));
        if (out_data.last !== want.last)
          report("last", int'(out_data.last), int'(want.last));
      end
    end
  end

  // Receiver back-pressure: runs of ready with stalls of random length between.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (streaming_out || $urandom_range(3) == 0) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
        out_ready = 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every bin is loaded before any sample; then writes past N/2 must be dropped.
  task automatic test_coef_load();
    for (int k = 0; k < NBINS; k++) begin
      if (k == 0) send_request(coef_req(k, 32767, -32768), pick_gap());
      else if (k == NPTS / 2) send_request(coef_req(k, -32768, 32767), pick_gap());
      else send_request(coef_req(k, $signed(16'($urandom)), $signed(16'($urandom))),
                        pick_gap());
    end
    send_request(coef_req(NBINS, 1, 1), 0);
    send_request(coef_req(63, -1, -1), pick_gap());
  endtask

  // Field extremes, unknown request, clear, and a one-sample flushed frame.
  task automatic test_directed();
    set_length(1);
    send_request(sample_req(32767, 1'b0), 0);
    send_request(sample_req(-32768, 1'b0), 0);
    send_request(sample_req(0, 1'b0), 1);
    send_request(sample_req(-1, 1'b1), 2);
    send_request(misc_req(2'd3), 0);
    send_request(misc_req(REQ_CLEAR), 0);
    send_request(sample_req(12345, 1'b1), 0);
    set_length(33);
    send_request(sample_req(32767, 1'b1), 0);
    send_request(sample_req(-32768, 1'b1), 0);
    send_request(misc_req(REQ_CLEAR), 0);
  endtask

  // Frame of 40 gathered at P=1, then P raised to 33: next sample closes an aliased frame.
  task automatic test_length_raise();
    set_length(1);
    for (int i = 0; i < 40; i++) send_request(sample_req(rand_sample(), 1'b0), pick_gap());
    set_length(33);
    send_request(sample_req(rand_sample(), 1'b0), 0);
  endtask

  // Random phases at several lengths; mostly samples with random content.
  task automatic test_random();
    int unsigned lens [6];
    int r;
    lens = '{33, 1, 17, $urandom_range(2, 32), 32, 2};
    foreach (lens[ph]) begin
      set_length(lens[ph]);
      streaming_out = (ph % 3 == 2);   // one phase in three with no output stalls
      for (int i = 0; i < 37; i++) begin
        if (ph == 3 && i == 26) drain();   // sender holds off until all owed samples are back
        r = $urandom_range(99);
        if (r < 84) send_request(sample_req(rand_sample(), $urandom_range(24) == 0), pick_gap());
        else if (r < 92) send_request(coef_req($urandom_range(9) == 0 ? $urandom_range(63)
                                                : $urandom_range(NBINS - 1),
                                                $signed(16'($urandom)),
                                                $signed(16'($urandom))), pick_gap());
        else if (r < 97) send_request(misc_req(REQ_CLEAR), pick_gap());
        else send_request(misc_req(2'd3), pick_gap());
      end
    end
    streaming_out = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    streaming_out = 1'b0;
    filt_len = 1;
    frame_cnt = 0;
    foreach (ovl[i]) ovl[i] = 0;
    foreach (frame_buf[i]) frame_buf[i] = 0;
    foreach (coef_re[i]) begin
      coef_re[i] = 0;
      coef_im[i] = 0;
    end
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_coef_load();
    test_directed();
    test_length_raise();
    test_random();
    drain();

    if (errors == 0) begin
      $display("fft_overlap_add_fir_filter_top: match");
    end else begin
      $display("fft_overlap_add_fir_filter_top: mismatch");
    end
    $finish;
  end

endmodule
